// ===== sv/saim_pkg.sv =====
// ----------------------------------------------------------------------------
// Strided access interval merger package
// Shared constants, action codes and the control and status bundles.
// ----------------------------------------------------------------------------
package saim_pkg;

  localparam int unsigned DefTableDepth = 64;
  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

  localparam logic [2:0] ActNew    = 3'd0;
  localparam logic [2:0] ActUp     = 3'd1;
  localparam logic [2:0] ActInside = 3'd2;
  localparam logic [2:0] ActDown   = 3'd3;
  localparam logic [2:0] ActFull   = 3'd4;
  localparam logic [2:0] ActRead   = 3'd5;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] stride;
    logic [31:0] count;
    logic [47:0] pc;
    logic [7:0]  kind;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic rd_user;
    logic emit_user;
    logic scan_rd;
    logic next;
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic commit;
    logic append;
    logic drop;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic at_fill;
    logic full;
    logic key_match;
    logic fits;
  } status_t;

endpackage

// ===== sv/saim_ctrl.sv =====
// ----------------------------------------------------------------------------
// Strided access interval merger controller
// Sequences the read of a requested entry, the table scan, the end computation
// and the write back.
module saim_ctrl import saim_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StRsel   = 4'd1;
  localparam logic [3:0] StRwait  = 4'd2;
  localparam logic [3:0] StScan   = 4'd3;
  localparam logic [3:0] StLoad   = 4'd4;
  localparam logic [3:0] StMulLo  = 4'd5;
  localparam logic [3:0] StMulHi  = 4'd6;
  localparam logic [3:0] StSum    = 4'd7;
  localparam logic [3:0] StDecide = 4'd8;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = StRsel;
        end
      end
      StRsel: begin
        if (status_i.is_read) begin
          cmd_o.rd_user = 1'b1;
          state_d       = StRwait;
        end else begin
          state_d = StScan;
        end
      end
      StRwait: begin
        cmd_o.emit_user = 1'b1;
        state_d         = StIdle;
      end
      StScan: begin
        if (status_i.at_fill) begin
          if (status_i.full) begin
            cmd_o.drop = 1'b1;
          end else begin
            cmd_o.append = 1'b1;
          end
          state_d = StIdle;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = StLoad;
        end
      end
      StLoad: begin
        if (status_i.key_match) begin
          cmd_o.load = 1'b1;
          state_d    = StMulLo;
        end else begin
          cmd_o.next = 1'b1;
          state_d    = StScan;
        end
      end
      StMulLo: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = StMulHi;
      end
      StMulHi: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = StSum;
      end
      StSum: begin
        cmd_o.sum = 1'b1;
        state_d   = StDecide;
      end
      StDecide: begin
        cmd_o.commit = 1'b1;
        if (status_i.fits) begin
          state_d = StIdle;
        end else begin
          cmd_o.next = 1'b1;
          state_d    = StScan;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// ===== sv/saim_dp.sv =====
// ----------------------------------------------------------------------------
// Strided access interval merger datapath
// Entry memory, scan index, fill level, end arithmetic and result register.
// ----------------------------------------------------------------------------
module saim_dp import saim_pkg::*; #(
  parameter int unsigned TableDepth = DefTableDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cmd_t         cmd_i,
  output status_t      status_o,
  input  logic         req_type_i,
  input  logic [63:0]  access_address_i,
  input  logic [47:0]  access_pc_i,
  input  logic [7:0]   access_size_type_i,
  input  logic [5:0]   read_index_i,
  output logic         result_valid_o,
  output logic [2:0]   action_o,
  output logic [5:0]   entry_index_o,
  output logic         entry_valid_o,
  output logic [63:0]  entry_base_o,
  output logic [63:0]  entry_stride_o,
  output logic [31:0]  entry_count_o,
  output logic [47:0]  entry_pc_o,
  output logic [7:0]   entry_size_type_o
);

  localparam int unsigned IdxW  = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned FillW = $clog2(TableDepth + 1);
  localparam int unsigned CmpW  = (FillW > 7) ? FillW : 7;

  entry_t mem [TableDepth];
  entry_t rd_q;
  logic              mem_we;
  logic [IdxW-1:0]   mem_wa;
  entry_t            mem_wd;
  logic              mem_re;
  logic [IdxW-1:0]   mem_ra;

  logic              req_type_q;
  logic [63:0]       addr_q;
  logic [47:0]       pc_q;
  logic [7:0]        st_q;
  logic [5:0]        rindex_q;
  logic              rd_ok_q;

  logic [FillW-1:0]  idx_q;
  logic [FillW-1:0]  fill_q;

  logic [63:0]       base_q;
  logic [63:0]       stride_q;
  logic [31:0]       count_q;
  logic [63:0]       plo_q;
  logic [31:0]       phi_q;
  logic [63:0]       end_q;

  logic              up, in_range, down, bump;
  entry_t            upd;
  entry_t            res_d;
  logic [2:0]        act_d;
  logic              emit;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  assign up       = (addr_q == end_q + stride_q);
  assign in_range = (addr_q >= base_q) && (addr_q <= end_q);
  assign down     = (addr_q == base_q - stride_q);
  assign bump     = (up || (!in_range && down)) && (count_q != CountMax);

  always_comb begin
    upd.base   = (!up && !in_range && down) ? addr_q : base_q;
    upd.stride = stride_q;
    upd.count  = bump ? count_q + 32'd1 : count_q;
    upd.pc     = pc_q;
    upd.kind   = st_q;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_q[IdxW-1:0];
    mem_wd = upd;
    if (cmd_i.commit) begin
      mem_we = 1'b1;
    end
    if (cmd_i.append) begin
      mem_we        = 1'b1;
      mem_wa        = fill_q[IdxW-1:0];
      mem_wd.base   = addr_q;
      mem_wd.stride = '0;
      mem_wd.count  = 32'd1;
      mem_wd.pc     = pc_q;
      mem_wd.kind   = st_q;
    end
    mem_re = cmd_i.rd_user || cmd_i.scan_rd;
    mem_ra = cmd_i.rd_user ? IdxW'(rindex_q) : idx_q[IdxW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_type_q <= req_type_i;
      addr_q     <= access_address_i;
      pc_q       <= access_pc_i;
      st_q       <= access_size_type_i;
      rindex_q   <= read_index_i;
    end
    if (cmd_i.rd_user) begin
      rd_ok_q <= (CmpW'(rindex_q) < CmpW'(fill_q));
    end
    if (cmd_i.load) begin
      base_q   <= rd_q.base;
      stride_q <= (rd_q.stride == '0) ? addr_q - rd_q.base : rd_q.stride;
      count_q  <= rd_q.count;
    end
    if (cmd_i.mul_lo) begin
      plo_q <= stride_q[31:0] * (count_q - 32'd1);
    end
    if (cmd_i.mul_hi) begin
      phi_q <= 32'(stride_q[63:32] * (count_q - 32'd1));
    end
    if (cmd_i.sum) begin
      end_q <= base_q + plo_q + {phi_q, 32'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      fill_q <= '0;
    end else begin
      if (cmd_i.latch) begin
        idx_q <= '0;
      end else if (cmd_i.next) begin
        idx_q <= idx_q + FillW'(1);
      end
      if (cmd_i.append) begin
        fill_q <= fill_q + FillW'(1);
      end
    end
  end

  assign status_o.is_read   = req_type_q;
  assign status_o.at_fill   = (idx_q >= fill_q);
  assign status_o.full      = (fill_q >= FillW'(TableDepth));
  assign status_o.key_match = (rd_q.pc == pc_q) && (rd_q.kind == st_q);
  assign status_o.fits      = up || in_range || down;

  always_comb begin
    res_d = upd;
    act_d = up ? ActUp : (in_range ? ActInside : ActDown);
    emit  = cmd_i.commit && (up || in_range || down);
    if (cmd_i.emit_user) begin
      emit  = 1'b1;
      act_d = ActRead;
      res_d = rd_ok_q ? rd_q : '0;
    end
    if (cmd_i.append) begin
      emit  = 1'b1;
      act_d = ActNew;
      res_d = mem_wd;
    end
    if (cmd_i.drop) begin
      emit         = 1'b1;
      act_d        = ActFull;
      res_d.base   = addr_q;
      res_d.stride = '0;
      res_d.count  = '0;
      res_d.pc     = pc_q;
      res_d.kind   = st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      action_o          <= act_d;
      entry_base_o      <= res_d.base;
      entry_stride_o    <= res_d.stride;
      entry_count_o     <= res_d.count;
      entry_pc_o        <= res_d.pc;
      entry_size_type_o <= res_d.kind;
      if (cmd_i.emit_user) begin
        entry_index_o <= rindex_q;
        entry_valid_o <= rd_ok_q;
      end else if (cmd_i.drop) begin
        entry_index_o <= '0;
        entry_valid_o <= 1'b0;
      end else if (cmd_i.append) begin
        entry_index_o <= 6'(fill_q);
        entry_valid_o <= 1'b1;
      end else begin
        entry_index_o <= 6'(idx_q);
        entry_valid_o <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/strided_access_interval_merger_unit.sv =====
// ----------------------------------------------------------------------------
// Strided access interval merger
// Folds memory accesses into strided intervals kept in an entry table.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A read request reads
// the requested entry from the entry memory and then emits it. An access scans
// the table one entry at a time through the entry memory: an entry with other
// keys is read and passed over; an entry with matching keys is read, loaded,
// its end is computed in two multiply steps and a sum, and it is written back
// and takes the access if it fits. After the last entry the access is appended
// or dropped. The slowest case is a table whose entries all match the keys and
// all pass the access over. The result appears for one cycle with result_valid_o
// and cannot be stalled; a new item may start in that cycle.
module strided_access_interval_merger_unit import saim_pkg::*; #(
  parameter int unsigned TableDepth = DefTableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic [63:0] access_address_i,
  input  logic [47:0] access_pc_i,
  input  logic [7:0]  access_size_type_i,
  input  logic [5:0]  read_index_i,
  output logic        result_valid_o,
  output logic [2:0]  action_o,
  output logic [5:0]  entry_index_o,
  output logic        entry_valid_o,
  output logic [63:0] entry_base_o,
  output logic [63:0] entry_stride_o,
  output logic [31:0] entry_count_o,
  output logic [47:0] entry_pc_o,
  output logic [7:0]  entry_size_type_o
);

  cmd_t    cmd;
  status_t status;

  saim_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  saim_dp #(
    .TableDepth (TableDepth)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .req_type_i         (req_type_i),
    .access_address_i   (access_address_i),
    .access_pc_i        (access_pc_i),
    .access_size_type_i (access_size_type_i),
    .read_index_i       (read_index_i),
    .result_valid_o     (result_valid_o),
    .action_o           (action_o),
    .entry_index_o      (entry_index_o),
    .entry_valid_o      (entry_valid_o),
    .entry_base_o       (entry_base_o),
    .entry_stride_o     (entry_stride_o),
    .entry_count_o      (entry_count_o),
    .entry_pc_o         (entry_pc_o),
    .entry_size_type_o  (entry_size_type_o)
  );

endmodule

// ===== bench/saim_checker.sv =====
// ----------------------------------------------------------------------------
// Strided access interval merger checker
// Watches the item and result channels of the merger, keeps its own copy of
// the interval table, predicts one result per accepted item and compares
// every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module saim_checker import saim_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        req_type_i,
  input  logic [63:0] access_address_i,
  input  logic [47:0] access_pc_i,
  input  logic [7:0]  access_size_type_i,
  input  logic [5:0]  read_index_i,
  input  logic        result_valid_i,
  input  logic [2:0]  action_i,
  input  logic [5:0]  entry_index_i,
  input  logic        entry_valid_i,
  input  logic [63:0] entry_base_i,
  input  logic [63:0] entry_stride_i,
  input  logic [31:0] entry_count_i,
  input  logic [47:0] entry_pc_i,
  input  logic [7:0]  entry_size_type_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [2:0] action;
    logic [5:0] index;
    logic       valid;
    entry_t     entry;
  } outcome_t;

  entry_t   table_q [DefTableDepth];
  int       entries_used;
  outcome_t outcome_queue[$];
  int       fails;

  assign fail_count_o = fails;
  assign pending_o    = outcome_queue.size();

  function automatic outcome_t report_entry(logic [2:0] act, int idx);
    outcome_t o;
    o.action = act;
    o.index  = idx[5:0];
    o.valid  = 1'b1;
    o.entry  = table_q[idx];
    return o;
  endfunction

  task automatic merge_access(input logic is_read, input logic [63:0] addr,
                              input logic [47:0] pc, input logic [7:0] st,
                              input logic [5:0] rd_idx);
    outcome_t    o;
    logic [63:0] lo_addr;
    logic [63:0] step;
    logic [63:0] hi_addr;
    o = '0;
    if (is_read) begin
      if (rd_idx < entries_used) begin
        o = report_entry(ActRead, rd_idx);
      end else begin
        o.action = ActRead;
        o.index  = rd_idx;
      end
      outcome_queue.push_front(o);
      return;
    end
    for (int i = 0; i < entries_used; i++) begin
      if (table_q[i].pc != pc || table_q[i].kind != st) continue;
      if (table_q[i].stride == 64'd0) table_q[i].stride = addr - table_q[i].base;
      lo_addr = table_q[i].base;
      step    = table_q[i].stride;
      hi_addr = lo_addr + step * ({32'd0, table_q[i].count} - 64'd1);
      if (addr == hi_addr + step) begin
        if (table_q[i].count != CountMax) table_q[i].count++;
        outcome_queue.push_front(report_entry(ActUp, i));
        return;
      end
      if (addr >= lo_addr && addr <= hi_addr) begin
        outcome_queue.push_front(report_entry(ActInside, i));
        return;
      end
      if (addr == lo_addr - step) begin
        table_q[i].base = addr;
        if (table_q[i].count != CountMax) table_q[i].count++;
        outcome_queue.push_front(report_entry(ActDown, i));
        return;
      end
    end
    if (entries_used >= DefTableDepth) begin
      o.action = ActFull;
      o.entry.base = addr;
      o.entry.pc = pc;
      o.entry.kind = st;
      outcome_queue.push_front(o);
      return;
    end
    table_q[entries_used] = '{base: addr, stride: 64'd0, count: 32'd1, pc: pc,
                              kind: st};
    outcome_queue.push_front(report_entry(ActNew, entries_used));
    entries_used++;
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s expected %h, got %h", $time, name, exp_val, act_val);
      fails++;
    end
  endtask

  initial begin
    entries_used = 0;
    fails = 0;
  end

  always @(posedge clk_i) begin
    outcome_t o;
    if (rst_ni) begin
      if (result_valid_i) begin
        if (outcome_queue.size() == 0) begin
          $display("%0t: result with no item outstanding, action %0d", $time, action_i);
          fails++;
        end else begin
          o = outcome_queue.pop_back();
          check_field("action", o.action, action_i);
          check_field("entry_index", o.index, entry_index_i);
          check_field("entry_valid", o.valid, entry_valid_i);
          check_field("entry_base", o.entry.base, entry_base_i);
          check_field("entry_stride", o.entry.stride, entry_stride_i);
          check_field("entry_count", o.entry.count, entry_count_i);
          check_field("entry_pc", o.entry.pc, entry_pc_i);
          check_field("entry_size_type", o.entry.kind, entry_size_type_i);
        end
      end
      if (start_i && !busy_i) begin
        merge_access(req_type_i, access_address_i, access_pc_i, access_size_type_i,
                     read_index_i);
      end
    end
  end

endmodule

// ===== bench/strided_access_interval_merger_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Strided access interval merger testbench
// Drives directed and random access and read items into the merger with
// random gaps, while the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module strided_access_interval_merger_unit_tb import saim_pkg::*;;

  localparam int CycleLimit = 3000000;
  localparam int NumKeys = 12;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        req_type_i;
  logic [63:0] access_address_i;
  logic [47:0] access_pc_i;
  logic [7:0]  access_size_type_i;
  logic [5:0]  read_index_i;
  logic        result_valid_o;
  logic [2:0]  action_o;
  logic [5:0]  entry_index_o;
  logic        entry_valid_o;
  logic [63:0] entry_base_o;
  logic [63:0] entry_stride_o;
  logic [31:0] entry_count_o;
  logic [47:0] entry_pc_o;
  logic [7:0]  entry_size_type_o;
  int          fail_count;
  int          pending;
  int          cycles;

  logic [63:0] key_anchor [NumKeys];
  logic [63:0] key_step [NumKeys];
  logic [47:0] key_pc [NumKeys];
  logic [7:0]  key_st [NumKeys];

  strided_access_interval_merger_unit dut (.*);

  saim_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .req_type_i, .access_address_i,
    .access_pc_i, .access_size_type_i, .read_index_i, .result_valid_i(result_valid_o),
    .action_i(action_o), .entry_index_i(entry_index_o), .entry_valid_i(entry_valid_o),
    .entry_base_i(entry_base_o), .entry_stride_i(entry_stride_o),
    .entry_count_i(entry_count_o), .entry_pc_i(entry_pc_o),
    .entry_size_type_i(entry_size_type_o), .fail_count_o(fail_count),
    .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_item(input logic rt, input logic [63:0] addr,
                           input logic [47:0] pc, input logic [7:0] st,
                           input logic [5:0] idx);
    int gap;
    start              <= 1'b1;
    req_type_i         <= rt;
    access_address_i   <= addr;
    access_pc_i        <= pc;
    access_size_type_i <= st;
    read_index_i       <= idx;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    gap = 0;
    case ($urandom_range(0, 9))
      0, 1, 2: gap = $urandom_range(1, 3);
      3:       gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : 0;
      default: gap = 0;
    endcase
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_access(input logic [63:0] addr, input logic [47:0] pc,
                             input logic [7:0] st);
    send_item(1'b0, addr, pc, st, 6'($urandom()));
  endtask

  task automatic send_read(input logic [5:0] idx);
    send_item(1'b1, rand64(), 48'(rand64()), 8'($urandom()), idx);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    int k;
    int j;
    cycles             = 0;
    rst_ni             = 1'b0;
    start              = 1'b0;
    req_type_i         = 1'b0;
    access_address_i   = '0;
    access_pc_i        = '0;
    access_size_type_i = '0;
    read_index_i       = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty reads, extreme keys and addresses, and every action but the full-table drop.
    send_read(6'd0);
    send_read(6'd63);
    send_access(64'd0, 48'd0, 8'h00);
    send_access(64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'hFF);
    send_access(64'd5, 48'hFFFF_FFFF_FFFF, 8'hFF);
    send_access(64'h1000, 48'h1234_5678_9ABC, 8'h42);
    send_access(64'h1010, 48'h1234_5678_9ABC, 8'h42);
    send_access(64'h1020, 48'h1234_5678_9ABC, 8'h42);
    send_access(64'h1010, 48'h1234_5678_9ABC, 8'h42);
    send_access(64'h0FF0, 48'h1234_5678_9ABC, 8'h42);
    send_access(64'h9000, 48'h1234_5678_9ABC, 8'h42);
    send_access(64'h1030, 48'h1234_5678_9ABC, 8'h42);
    send_access(64'h9008, 48'h1234_5678_9ABC, 8'h42);
    send_access(64'h1000, 48'h1234_5678_9ABC, 8'h43);
    send_access(64'h0, 48'd0, 8'h00);
    send_access(64'h8000_0000_0000_0000, 48'd0, 8'h00);
    for (int i = 0; i < 8; i++) send_read(6'(i));
    wait_drained();

    for (int i = 0; i < NumKeys; i++) begin
      key_anchor[i] = rand64();
      key_step[i]   = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(1, 64));
      key_pc[i]     = 48'(rand64());
      key_st[i]     = 8'($urandom());
    end

    for (int n = 0; n < 1400; n++) begin
      if (n == 700) wait_drained();
      case ($urandom_range(0, 9))
        0: send_read(6'($urandom()));
        1: send_access(rand64(), 48'(rand64()), 8'($urandom()));
        2: begin
          k = $urandom_range(0, NumKeys - 1);
          send_access(rand64(), key_pc[k], key_st[k]);
        end
        default: begin
          k = $urandom_range(0, NumKeys - 1);
          j = $urandom_range(0, 14) - 3;
          send_access(key_anchor[k] + key_step[k] * 64'(signed'(j)), key_pc[k], key_st[k]);
        end
      endcase
    end
    for (int i = 0; i < 64; i++) send_read(6'(i));

    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/saim_pkg.sv
sv/saim_ctrl.sv
sv/saim_dp.sv
sv/strided_access_interval_merger_unit.sv
bench/saim_checker.sv
bench/strided_access_interval_merger_unit_tb.sv
